// ----- hw/rtl/power_sign_gradient_scaler_core_macros.svh -----
// Assertion macros of the power-sign gradient scaler core.
`ifndef POWER_SIGN_GRADIENT_SCALER_CORE_MACROS_SVH
`define POWER_SIGN_GRADIENT_SCALER_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PSGS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PSGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/psgs_pkg.sv -----
// Package with constants and shared types of the power-sign gradient scaler.
package psgs_pkg;
  localparam int unsigned Depth    = 4096;
  localparam int unsigned IdxW     = 12;
  localparam int unsigned AddrW    = 12;
  localparam logic [16:0] QOne     = 17'd65536;
  localparam logic [16:0] Beta1Rst = 17'd58982;
  localparam logic [19:0] BaseRst  = 20'd178145;
  localparam logic [1:0]  RegBeta1 = 2'd0;
  localparam logic [1:0]  RegBase  = 2'd1;
  localparam logic [1:0]  RegDecay = 2'd2;

  // Work request to the power unit and its answer.
  typedef struct packed {
    logic        start;
    logic [19:0] base;
    logic [16:0] expo;
  } pow_req_t;

  typedef struct packed {
    logic        done;
    logic [35:0] pos;   // base^e, Q16
    logic [35:0] neg;   // round(2^32 / pos); not valid when zero is set
    logic        zero;
  } pow_rsp_t;

  function automatic logic [16:0] clamp_one(input logic [16:0] v);
    return (v > QOne) ? QOne : v;
  endfunction
endpackage

// ----- hw/rtl/power_sign_gradient_scaler_core.sv -----
// Top level of the power-sign gradient scaler.
// Usage:
// s_axis carries one gradient element per beat; tdata holds element_index,
// grad_in and hess_in, tlast holds batch_last. m_axis returns grad_out and
// hess_out in tdata and out_last in tlast, one result beat per input beat.
// cfg writes beta1_coefficient (0), power_base (1) and exponent_decay (2);
// other indexes are dropped. Write configuration only while the block is idle.
// An element takes a read of the average memory, an update, the multiply and
// its write-back: the states StRead, StUpd and StMul, then StOut offers the
// result; the block takes one item at a time. From the second batch on, the
// power factor is formed in StPow by the power unit at a batch's first element
// (17 multiply steps, 16 square roots of 28 steps and a 34-step divide).
// Reset clears the batch counter and the first-batch flag and sets the decay
// power to one; the average memory is not cleared, every element is written in batch one.
// When m_axis_tready is low the result is held in the output register and no
// further input beat is taken until it leaves.
module power_sign_gradient_scaler_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,   // element_index, grad_in, hess_in, 4 unused bits
  input  logic         s_axis_tlast,   // batch_last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // grad_out, hess_out
  output logic         m_axis_tlast,   // out_last
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [19:0]  cfg_wdata
);
  import psgs_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPow  = 3'd1;
  localparam logic [2:0] StRead = 3'd2;
  localparam logic [2:0] StUpd  = 3'd3;
  localparam logic [2:0] StMul  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]  st_q, st_d;
  logic [16:0] beta1_q, decay_q;
  logic [19:0] base_q;
  logic [31:0] batch_cnt_q;
  logic        first_done_q;
  logic [16:0] decay_pow_q;
  logic        pow_valid_q;
  logic        preq_sent_q;
  logic [35:0] fpos_q, fneg_q;
  logic        fzero_q;

  logic [IdxW-1:0]  idx_q;
  logic signed [31:0] g_q, h_q, m_rd_q, nm_q, res_q;
  logic        last_q;
  logic        mem_we;
  logic signed [31:0] mem [Depth];

  logic [16:0] b_cl, dec_cl, e_cur;
  logic [33:0] dp_prod;
  logic signed [51:0] ma_sum;
  logic [51:0] ma_mag;
  logic [35:0] ma_q;
  logic signed [31:0] nm_w;
  logic [31:0] g_mag;
  logic [64:0] sc_prod;
  logic [35:0] sc_q;
  logic [35:0] factor;
  logic signed [31:0] sat_w;
  logic        in_range, pos_sign, neg_sign;
  logic        s_hs, m_hs;
  pow_req_t    preq;
  pow_rsp_t    prsp;

  assign b_cl    = clamp_one(beta1_q);
  assign dec_cl  = clamp_one(decay_q);
  assign dp_prod = decay_pow_q * dec_cl;
  assign e_cur   = 17'((dp_prod + 34'h8000) >> 16);
  assign in_range = ({20'd0, idx_q} < 32'(Depth));

  // Moving average: (b*m + (1-b)*g) / 65536, rounded half away from zero.
  assign ma_sum = $signed({1'b0, b_cl}) * m_rd_q
                + $signed({1'b0, 17'(QOne - b_cl)}) * g_q;
  assign ma_mag = ma_sum[51] ? 52'(-ma_sum) : 52'(ma_sum);
  assign ma_q   = 36'((ma_mag + 52'h8000) >> 16);
  assign nm_w   = ma_sum[51] ? -$signed(ma_q[31:0]) : $signed(ma_q[31:0]);

  assign pos_sign = (g_q > 0 && nm_q > 0) || (g_q < 0 && nm_q < 0);
  assign neg_sign = (g_q > 0 && nm_q < 0) || (g_q < 0 && nm_q > 0);
  assign factor   = pos_sign ? fpos_q : fneg_q;
  assign g_mag    = g_q[31] ? 32'(-g_q) : 32'(g_q);
  // The factor never exceeds 2^32, so 33 bits of it suffice.
  assign sc_prod  = g_mag * factor[32:0];
  // A product of 2^47 or more saturates whatever the sign.
  assign sc_q     = (sc_prod[64:47] != 18'd0) ? 36'hF_FFFF_FFFF
                  : 36'((sc_prod + 65'h8000) >> 16);
  always_comb begin
    if (g_q[31]) sat_w = (sc_q >= 36'h8000_0000) ? 32'sh8000_0000 : -$signed(sc_q[31:0]);
    else         sat_w = (sc_q >= 36'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(sc_q[31:0]);
  end

  assign s_hs = s_axis_tvalid && s_axis_tready;
  assign m_hs = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (st_q == StIdle);
  assign cfg_ready = 1'b1;

  assign preq.start = (st_q == StPow) && !pow_valid_q && !prsp.done && !preq_sent_q;
  assign preq.base  = base_q;
  assign preq.expo  = e_cur;

  psgs_power u_power (.clk_i, .rst_ni, .req_i(preq), .rsp_o(prsp));

  always_comb begin
    st_d = st_q;
    mem_we = 1'b0;
    unique case (st_q)
      StIdle: if (s_hs) st_d = StRead;
      StRead: st_d = (first_done_q && !pow_valid_q) ? StPow : StUpd;
      StPow:  if (prsp.done) st_d = StUpd;
      StUpd:  st_d = StMul;
      StMul: begin
        mem_we = in_range;
        st_d = StOut;
      end
      StOut:  if (m_hs) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      beta1_q <= Beta1Rst; base_q <= BaseRst; decay_q <= QOne;
      batch_cnt_q <= 32'd0; first_done_q <= 1'b0; decay_pow_q <= QOne;
      pow_valid_q <= 1'b0; preq_sent_q <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          RegBeta1: beta1_q <= cfg_wdata[16:0];
          RegBase:  base_q  <= cfg_wdata;
          RegDecay: decay_q <= cfg_wdata[16:0];
          default: ;
        endcase
        pow_valid_q <= 1'b0;
      end
      if (preq.start) preq_sent_q <= 1'b1;
      if (prsp.done) begin
        pow_valid_q <= 1'b1;
        preq_sent_q <= 1'b0;
      end
      if (st_q == StMul) m_axis_tvalid <= 1'b1;
      else if (m_hs) m_axis_tvalid <= 1'b0;
      // Batch state advances once the last element's result is formed.
      if (st_q == StMul && last_q) begin
        batch_cnt_q  <= batch_cnt_q + 32'd1;
        first_done_q <= 1'b1;
        decay_pow_q  <= e_cur;
        pow_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      idx_q  <= s_axis_tdata[11:0];
      g_q    <= s_axis_tdata[43:12];
      h_q    <= s_axis_tdata[75:44];
      last_q <= s_axis_tlast;
    end
    if (st_q == StRead) m_rd_q <= mem[idx_q[AddrW-1:0]];
    if (prsp.done) begin
      fpos_q  <= prsp.pos;
      fneg_q  <= prsp.neg;
      fzero_q <= prsp.zero;
    end
    if (st_q == StUpd) nm_q <= first_done_q ? nm_w : g_q;
    if (mem_we) mem[idx_q[AddrW-1:0]] <= nm_q;
    if (st_q == StMul) begin
      if (!in_range || !first_done_q || (!pos_sign && !neg_sign)) res_q <= g_q;
      else if (neg_sign && fzero_q) res_q <= g_q[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else res_q <= sat_w;
    end
  end

  assign m_axis_tdata = {h_q, res_q};
  assign m_axis_tlast = last_q;

  logic unused_cnt;
  assign unused_cnt = ^batch_cnt_q;

  `include "power_sign_gradient_scaler_core_macros.svh"

  `PSGS_ASSERT_IMPL(a_no_take_busy, st_q != StIdle, !s_axis_tready, "input taken while busy")
  `PSGS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
  `PSGS_ASSERT_IMPL(a_write_range, mem_we, in_range, "average written out of range")
endmodule

// ----- hw/rtl/psgs_power.sv -----
// Sequential unit that forms base^e and its reciprocal with square roots and a divider.
module psgs_power (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psgs_pkg::pow_req_t req_i,
  output psgs_pkg::pow_rsp_t rsp_o
);
  import psgs_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSqrt = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]  st_q, st_d;
  logic [4:0]  k_q, k_d;        // bit of the exponent being handled
  logic [5:0]  it_q, it_d;      // iteration counter of the sqrt and divide loops
  logic [16:0] e_q, e_d;
  logic [35:0] r_q, r_d;        // current root, Q16
  logic [35:0] acc_q, acc_d;
  logic [55:0] sv_q, sv_d;      // radicand remainder
  logic [35:0] sres_q, sres_d;
  logic [55:0] sbit_q, sbit_d;
  logic [33:0] dn_q, dn_d;      // divider numerator remainder
  logic [33:0] dq_q, dq_d;
  logic [41:0] prod;
  logic [55:0] strial;
  logic [36:0] dtrial;

  // The exponent never exceeds one, so the accumulator and the roots stay below 2^21.
  assign prod   = acc_q[20:0] * r_q[20:0];
  assign strial = sres_q + sbit_q;
  assign dtrial = {dn_q[32:0], dq_q[33]} - {1'b0, acc_q};

  always_comb begin
    st_d = st_q; k_d = k_q; it_d = it_q; e_d = e_q; r_d = r_q; acc_d = acc_q;
    sv_d = sv_q; sres_d = sres_q; sbit_d = sbit_q; dn_d = dn_q; dq_d = dq_q;
    unique case (st_q)
      StIdle: begin
        if (req_i.start) begin
          e_d   = req_i.expo;
          r_d   = {16'd0, req_i.base};
          acc_d = 36'd65536;
          k_d   = 5'd16;
          st_d  = StMul;
        end
      end
      StMul: begin
        // Multiply in the current root when its exponent bit is set.
        if (e_q[k_q]) acc_d = 36'((prod + 42'h8000) >> 16);
        if (k_q == 5'd0) begin
          st_d = StDiv; it_d = 6'd0; dn_d = 34'd0; dq_d = 34'h1_0000_0000 + 34'(acc_d >> 1);
        end else begin
          sv_d = 56'(r_q) << 16;
          sres_d = 36'd0; sbit_d = 56'd1 << 54; it_d = 6'd0;
          st_d = StSqrt;
        end
      end
      StSqrt: begin
        // One result bit of the integer square root per cycle.
        if (sv_q >= strial) begin
          sv_d   = sv_q - strial;
          sres_d = 36'((56'(sres_q) >> 1) + sbit_q);
        end else begin
          sres_d = sres_q >> 1;
        end
        sbit_d = sbit_q >> 2;
        it_d   = it_q + 6'd1;
        if (it_q == 6'd27) begin
          r_d  = sres_d;
          k_d  = k_q - 5'd1;
          st_d = StMul;
        end
      end
      StDiv: begin
        // Restoring division of 2^32 + p/2 by p, one quotient bit per cycle.
        if (acc_q == 36'd0) begin
          st_d = StDone;
        end else begin
          if (!dtrial[36]) begin
            dn_d = dtrial[33:0];
            dq_d = {dq_q[32:0], 1'b1};
          end else begin
            dn_d = {dn_q[32:0], dq_q[33]};
            dq_d = {dq_q[32:0], 1'b0};
          end
          it_d = it_q + 6'd1;
          if (it_q == 6'd33) st_d = StDone;
        end
      end
      StDone:  st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      k_q  <= 5'd0;
      it_q <= 6'd0;
    end else begin
      st_q <= st_d;
      k_q  <= k_d;
      it_q <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q <= e_d; r_q <= r_d; acc_q <= acc_d; sv_q <= sv_d; sres_q <= sres_d;
    sbit_q <= sbit_d; dn_q <= dn_d; dq_q <= dq_d;
  end

  assign rsp_o.done = (st_q == StDone);
  assign rsp_o.pos  = acc_q;
  assign rsp_o.neg  = {2'd0, dq_q};
  assign rsp_o.zero = (acc_q == 36'd0);
endmodule

// ----- dv/tb_power_sign_gradient_scaler_core.sv -----
// Self-checking testbench for the power-sign gradient scaler core.
`timescale 1ns / 1ps

module tb_power_sign_gradient_scaler_core;
  import psgs_pkg::*;

  typedef struct {
    logic [11:0]        idx;
    logic signed [31:0] grad;
    logic [31:0]        hess;
    logic               last;
  } grad_beat_t;

  typedef struct {
    logic [31:0] grad;
    logic [31:0] hess;
    logic        last;
  } scaled_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_wdata = '0;

  grad_beat_t   grad_pending[$];
  scaled_beat_t scaled_expected[$];
  int           error_count = 0;
  int           cfg_beats = 0;
  int           tx_gap_max = 0;
  int           rx_gap_max = 0;
  int           tx_wait = 0;
  int           rx_wait = 0;
  logic         hold_kick = 1'b0;
  logic         hold_used = 1'b0;
  int           hold_left = 0;

  // Shadow state of the block.
  logic [16:0]        beta_reg = Beta1Rst;
  logic [19:0]        base_reg = BaseRst;
  logic [16:0]        decay_reg = QOne;
  logic signed [31:0] avg_mem[Depth];
  logic [31:0]        batches_done = '0;
  logic               first_done = 1'b0;
  logic [16:0]        decay_acc = QOne;

  // Generator view: which averages have been loaded.
  logic [11:0]        loaded_idx[$];
  logic               gen_first_done = 1'b0;

  power_sign_gradient_scaler_core uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] base_power(input logic [19:0] b, input logic [16:0] e);
    logic [63:0] acc, r;
    acc = 64'd65536;
    r = {44'd0, b};
    if (e[16]) acc = (acc * r + 64'h8000) >> 16;
    for (int k = 15; k >= 0; k--) begin
      r = int_sqrt(r << 16);
      if (e[k]) acc = (acc * r + 64'h8000) >> 16;
    end
    return acc;
  endfunction

  function automatic logic [31:0] scale_saturate(input logic signed [31:0] g,
                                                 input logic [63:0] f);
    logic [63:0] mag, q;
    mag = g < 0 ? 64'd0 - 64'(signed'(g)) : 64'(g);
    q = (mag * f + 64'h8000) >> 16;
    if (g < 0) return q >= 64'h8000_0000 ? 32'h8000_0000 : 32'(64'd0 - q);
    return q >= 64'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  function automatic logic signed [63:0] div_q16_round(input logic signed [63:0] v);
    logic [63:0] mag, q;
    mag = v < 0 ? 64'd0 - v : v;
    q = (mag + 64'h8000) >> 16;
    return v < 0 ? -$signed(q) : $signed(q);
  endfunction

  // Works out the result of one gradient beat and advances the shadow state.
  function automatic scaled_beat_t scale_gradient(input grad_beat_t it);
    scaled_beat_t       res;
    logic [16:0]        dec, e;
    logic signed [63:0] b, m;
    logic signed [31:0] nm;
    logic [63:0]        p, f;
    int                 sg, sm;
    dec = clamp_one(decay_reg);
    res.grad = it.grad;
    res.hess = it.hess;
    res.last = it.last;
    if (!first_done) begin
      avg_mem[it.idx] = it.grad;
    end else begin
      b = 64'(clamp_one(beta_reg));
      m = avg_mem[it.idx];
      nm = 32'(div_q16_round(b * m + (64'sd65536 - b) * 64'(it.grad)));
      avg_mem[it.idx] = nm;
      sg = (it.grad > 0) - (it.grad < 0);
      sm = (nm > 0) - (nm < 0);
      if (sg * sm != 0) begin
        e = 17'((64'(decay_acc) * 64'(dec) + 64'h8000) >> 16);
        p = base_power(base_reg, e);
        if (sg * sm > 0) begin
          res.grad = scale_saturate(it.grad, p);
        end else if (p == 0) begin
          res.grad = it.grad < 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          f = ((64'd1 << 32) + p / 2) / p;
          res.grad = scale_saturate(it.grad, f);
        end
      end
    end
    if (it.last) begin
      batches_done = batches_done + 1;
      first_done = 1'b1;
      decay_acc = 17'((64'(decay_acc) * 64'(dec) + 64'h8000) >> 16);
    end
    return res;
  endfunction

  // Sender: one beat at a time from the pending queue, with random gaps.
  always @(posedge clk_i) begin
    grad_beat_t cur, nxt;
    logic       keep;
    if (s_axis_tvalid && s_axis_tready) begin
      cur.idx = s_axis_tdata[11:0];
      cur.grad = s_axis_tdata[43:12];
      cur.hess = s_axis_tdata[75:44];
      cur.last = s_axis_tlast;
      scaled_expected.push_back(scale_gradient(cur));
    end
    keep = s_axis_tvalid && !s_axis_tready;
    if (rst_ni && !keep) begin
      if (tx_wait > 0) begin
        tx_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (grad_pending.size() > 0) begin
        nxt = grad_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, nxt.hess, nxt.grad, nxt.idx};
        s_axis_tlast <= nxt.last;
        tx_wait = $urandom_range(0, tx_gap_max);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here while the sender keeps offering beats.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_kick && !hold_used) begin
      hold_left <= 400;
      hold_used <= 1'b1;
    end
  end

  // Receiver and checker.
  always @(posedge clk_i) begin
    scaled_beat_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (scaled_expected.size() == 0) begin
        $error("unexpected result beat: grad_out %h", m_axis_tdata[31:0]);
        error_count++;
      end else begin
        want = scaled_expected.pop_front();
        if (m_axis_tdata[31:0] !== want.grad) begin
          $error("grad_out expected %h actual %h", want.grad, m_axis_tdata[31:0]);
          error_count++;
        end
        if (m_axis_tdata[63:32] !== want.hess) begin
          $error("hess_out expected %h actual %h", want.hess, m_axis_tdata[63:32]);
          error_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("out_last expected %b actual %b", want.last, m_axis_tlast);
          error_count++;
        end
      end
      rx_wait = $urandom_range(0, rx_gap_max);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    m_axis_tready <= rst_ni && rx_wait == 0 && hold_left == 0;
  end

  always @(posedge clk_i) begin
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegBeta1: beta_reg <= cfg_wdata[16:0];
        RegBase:  base_reg <= cfg_wdata;
        RegDecay: decay_reg <= cfg_wdata[16:0];
        default: ;
      endcase
      cfg_beats <= cfg_beats + 1;
    end
  end

  task automatic write_reg(input logic [1:0] index, input logic [19:0] value);
    int seen;
    seen = cfg_beats;
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    wait (cfg_beats != seen);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (grad_pending.size() == 0 && scaled_expected.size() == 0 && !s_axis_tvalid);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic queue_beat(input logic [11:0] idx, input logic [31:0] grad,
                            input logic [31:0] hess, input logic last);
    grad_beat_t it;
    it.idx = idx;
    it.grad = grad;
    it.hess = hess;
    it.last = last;
    if (!gen_first_done) loaded_idx.push_back(idx);
    if (last) gen_first_done = 1'b1;
    grad_pending.push_back(it);
  endtask

  function automatic logic [31:0] random_grad();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 2000) - 1000;
      1: return 32'd0;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'd1;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random_batches(input int count);
    int n, left;
    left = count;
    while (left > 0) begin
      n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 30);
      if (n > left) n = left;
      for (int i = 0; i < n; i++)
        queue_beat(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)],
                   random_grad(), $urandom, i == n - 1);
      left -= n;
    end
  endtask

  initial begin
    logic [19:0] beta_set[8]  = '{58982, 0, 65536, 131071, 30000, 58982, 12345, 65000};
    logic [19:0] base_set[8]  = '{178145, 655360, 0, 1048575, 100000, 178145, 65536, 300000};
    logic [19:0] decay_set[8] = '{65536, 65536, 65536, 0, 40000, 131071, 60000, 65535};
    logic [11:0] first_idx[12] = '{0, 1, 2, 3, 4, 5, 6, 7, 2048, 1365, 2730, 4095};
    logic [31:0] first_grad[12] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF,
                                    32'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                                    32'h1234_5678, 32'hEDCB_A988, 32'h0010_0000,
                                    32'hFFF0_0000};
    logic [31:0] second_grad[12] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd5,
                                     32'h0001_0000, 32'd0, 32'hFFFF_0000, 32'hFFFF_8000,
                                     32'h4000_0000, 32'h8000_0000, 32'hFFF0_0000,
                                     32'h0010_0000};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First batch loads every average that later batches may read.
    for (int i = 0; i < 12; i++)
      queue_beat(first_idx[i], first_grad[i], i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, i == 11);
    // Second batch: matching and opposite signs, zero and saturating gradients.
    for (int i = 0; i < 12; i++)
      queue_beat(first_idx[i], second_grad[i], i[0] ? 32'hFFFF_FFFF : 32'h0, i == 11);
    wait_drained();
    write_reg(2'd3, 20'hFFFFF);

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(RegBeta1, beta_set[ph]);
      write_reg(RegBase, base_set[ph]);
      write_reg(RegDecay, decay_set[ph]);
      tx_gap_max = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 3 : 18);
      rx_gap_max = (ph % 4 == 1) ? 0 : ((ph % 2 == 0) ? 18 : 2);
      if (ph == 2) begin
        @(posedge clk_i);
        hold_kick <= 1'b1;
      end
      queue_random_batches(240);
      wait_drained();
    end

    wait (grad_pending.size() == 0 && scaled_expected.size() == 0 && !s_axis_tvalid);
    repeat (50) @(posedge clk_i);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #25ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
